// ----- hw/rtl/c3f_pkg.sv -----
// Shared constants, register codes and types of the 3x3 clamped pixel filter.
`timescale 1ns / 1ps
`default_nettype none

package c3f_pkg;

  // Image geometry.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 10;
  localparam int DIM_W      = 11;

  // Pixel and weight formats.
  localparam int PIX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 8;
  localparam int LS_W           = 2 * PIX_W;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam int MIN_DIM        = 3;

  // Arithmetic widths: one product, a column of three, the whole window.
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int SUM_W  = PSUM_W + 2;

  // Configuration port.
  localparam int CFG_W      = 3 * COEF_W;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEFF_TOP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEFF_MID    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEFF_BOTTOM = 3'd4;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [CFG_W-1:0] COEFF_MID_RESET = 48'h0000_0100_0000;

  // Result bus packing.
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - PIX_W - 2 * ROW_W;

  // One window column: upper, middle and lower pixel, upper in the top bits.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // The three signed weights that apply to one window column.
  typedef struct packed {
    logic [COEF_W-1:0] top;
    logic [COEF_W-1:0] mid;
    logic [COEF_W-1:0] bot;
  } wcol_t;

  // Per-cycle control of a window cell.
  typedef struct packed {
    logic shift;
    logic capture;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/conv3x3_clamped_pixel_filter.sv -----
// Top level of the 3x3 clamped pixel filter: counters, line store, window cell chain, output.
//
//  Channel | Ports                        | Payload
//  --------+------------------------------+------------------------------------------------
//  in      | in_tvalid/in_tready          | in_tdata[7:0] pixel_in, in_tuser frame_start
//  out     | out_tvalid/out_tready        | out_tdata pixel_out, out_row, out_col; out_tlast
//  cfg     | cfg_wr_en/cfg_addr/cfg_wdata | register index and value, write only
//
// One pixel is taken every clock cycle unless the output stalls with every stage full.
// A result passes the stage chain: accept, line store read, window shift, products,
// sum and clamp into the output register.
// Reset clears counters, window, valid flags and settings; the line store is not cleared.
// A stalled output holds its result, and stages behind it keep filling until all are full.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_clamped_pixel_filter import c3f_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Pixel requests.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  wire logic                  in_tuser,   // [0] frame_start
  // Filtered results.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [7:0] pixel_out, [17:8] out_row,
                                                 // [27:18] out_col, [31:28] zero
  output logic                       out_tlast,  // frame_last
  // Configuration writes.
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } tag_t;

  // Configuration registers.
  logic [DIM_W-1:0] width_r, height_r;
  logic [CFG_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      coef_top_r <= '0;
      coef_mid_r <= COEFF_MID_RESET;
      coef_bot_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r    <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r   <= cfg_wdata[DIM_W-1:0];
        REG_COEFF_TOP:    coef_top_r <= cfg_wdata;
        REG_COEFF_MID:    coef_mid_r <= cfg_wdata;
        REG_COEFF_BOTTOM: coef_bot_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Dimensions held to the supported range.
  logic [DIM_W-1:0] w_eff, h_eff;

  always_comb begin
    if (width_r < DIM_W'(MIN_DIM)) begin
      w_eff = DIM_W'(MIN_DIM);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Stage flow: a stage takes a new entry when it is empty or its entry moves on.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic take1, take2, take3, take4, take5;
  tag_t s3_tag_r, s4_tag_r;

  assign take5 = !v5_r || out_tready;
  assign take4 = !v4_r || take5;
  assign take3 = !v3_r || take4;
  assign take2 = !v2_r || take3;
  assign take1 = !v1_r || take2;

  assign in_tready = take1;

  logic acc;
  assign acc = in_tvalid && take1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (take1) v1_r <= in_tvalid;
      if (take2) v2_r <= v1_r;
      if (take3) v3_r <= v2_r;
      if (take4) v4_r <= v3_r;
      if (take5) v5_r <= v4_r && s4_tag_r.emit;
    end
  end

  // Position counters; a frame start puts the pixel at the origin.
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt, pos_col;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt, pos_row;
  logic [DIM_W-1:0] col_inc, row_inc;

  assign pos_col = in_tuser ? '0 : col_cnt_r;
  assign pos_row = in_tuser ? '0 : row_cnt_r;
  assign col_inc = DIM_W'(pos_col) + DIM_W'(1);
  assign row_inc = DIM_W'(pos_row) + DIM_W'(1);

  always_comb begin
    if (col_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
    end else begin
      col_cnt_nxt = COL_W'(col_inc);
      row_cnt_nxt = pos_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Stage 1: accepted pixel and its position.
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r <= in_tdata;
      s1_col_r <= pos_col;
      s1_row_r <= pos_row;
    end
  end

  // Whether this pixel closes a window around an interior centre, and where it lies.
  tag_t             s1_tag;
  logic [DIM_W-1:0] s1_col_d, s1_row_d;

  assign s1_col_d = DIM_W'(s1_col_r);
  assign s1_row_d = DIM_W'(s1_row_r);

  always_comb begin
    s1_tag.emit = (s1_row_d >= DIM_W'(2)) && (s1_col_d >= DIM_W'(2)) &&
                  (s1_col_d < w_eff) && (s1_row_d < h_eff);
    s1_tag.last = (s1_row_d == h_eff - DIM_W'(1)) && (s1_col_d == w_eff - DIM_W'(1));
    s1_tag.row  = ROW_W'(s1_row_r - ROW_W'(1));
    s1_tag.col  = ROW_W'(s1_col_r - COL_W'(1));
  end

  // Line store access: read when a pixel enters stage 2, write when it leaves.
  logic             mem_rd_en, mem_wr_en;
  logic [LS_W-1:0]  mem_rd_data, mem_wr_data;
  logic [COL_W-1:0] s2_col_r;
  logic [PIX_W-1:0] s2_pix_r;
  tag_t             s2_tag_r;
  logic             fwd_hit_r;
  logic [LS_W-1:0]  fwd_data_r;
  logic [LS_W-1:0]  s2_ls;

  assign mem_rd_en   = take2 && v1_r;
  assign mem_wr_en   = take3 && v2_r;
  assign mem_wr_data = {s2_ls[PIX_W-1:0], s2_pix_r};

  c3f_line_mem u_line_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (s2_col_r),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (s1_col_r),
    .rd_data (mem_rd_data)
  );

  // A write to the same column in the read cycle is bypassed around the memory.
  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      fwd_hit_r  <= mem_wr_en && (s2_col_r == s1_col_r);
      fwd_data_r <= mem_wr_data;
      s2_col_r   <= s1_col_r;
      s2_pix_r   <= s1_pix_r;
      s2_tag_r   <= s1_tag;
    end
  end

  assign s2_ls = fwd_hit_r ? fwd_data_r : mem_rd_data;

  // New column formed from the two stored rows and the incoming pixel.
  col_t new_col;
  assign new_col.top = s2_ls[LS_W-1:PIX_W];
  assign new_col.mid = s2_ls[PIX_W-1:0];
  assign new_col.bot = s2_pix_r;

  // Window cell chain: the newest column enters cell 0 and moves left each request.
  cell_ctl_t                cell_ctl;
  col_t                     col0, col1, col2;
  wcol_t                    wts0, wts1, wts2;
  logic signed [PSUM_W-1:0] psum0, psum1, psum2;

  assign cell_ctl.shift   = mem_wr_en;
  assign cell_ctl.capture = take4 && v3_r;

  // Cell 0 holds the right column, cell 1 the centre, cell 2 the left.
  assign wts0 = '{top: coef_top_r[3*COEF_W-1:2*COEF_W],
                  mid: coef_mid_r[3*COEF_W-1:2*COEF_W],
                  bot: coef_bot_r[3*COEF_W-1:2*COEF_W]};
  assign wts1 = '{top: coef_top_r[2*COEF_W-1:COEF_W],
                  mid: coef_mid_r[2*COEF_W-1:COEF_W],
                  bot: coef_bot_r[2*COEF_W-1:COEF_W]};
  assign wts2 = '{top: coef_top_r[COEF_W-1:0],
                  mid: coef_mid_r[COEF_W-1:0],
                  bot: coef_bot_r[COEF_W-1:0]};

  c3f_cell u_cell0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cell_ctl),
    .col_in  (new_col),
    .wts     (wts0),
    .col_out (col0),
    .psum    (psum0)
  );

  c3f_cell u_cell1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cell_ctl),
    .col_in  (col0),
    .wts     (wts1),
    .col_out (col1),
    .psum    (psum1)
  );

  c3f_cell u_cell2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cell_ctl),
    .col_in  (col1),
    .wts     (wts2),
    .col_out (col2),
    .psum    (psum2)
  );

  // Tags follow the window through stages 3 and 4; the last cell's column leaves the chain.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      s3_tag_r <= s2_tag_r;
    end
    if (cell_ctl.capture) begin
      s4_tag_r <= s3_tag_r;
    end
  end

  // Window sum, clamped to the pixel range and truncated to an integer.
  logic signed [SUM_W-1:0] total;
  logic [PIX_W-1:0]        clamped;
  logic                    unused_tail;

  assign total = SUM_W'(psum0) + SUM_W'(psum1) + SUM_W'(psum2);
  assign unused_tail = ^col2;

  always_comb begin
    if (total[SUM_W-1]) begin
      clamped = '0;
    end else if (|total[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
      clamped = PIX_MAX;
    end else begin
      clamped = total[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
    end
  end

  // Output register.
  logic [PIX_W-1:0] out_pix_r;
  logic [ROW_W-1:0] out_row_r, out_col_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (take5) begin
      out_pix_r  <= clamped;
      out_row_r  <= s4_tag_r.row;
      out_col_r  <= s4_tag_r.col;
      out_last_r <= s4_tag_r.last ^ (unused_tail & 1'b0);
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_col_r, out_row_r, out_pix_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/c3f_line_mem.sv -----
// Line store: two previous rows of pixels per column, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module c3f_line_mem import c3f_pkg::*; (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire logic [LS_W-1:0]  wr_data,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  output logic      [LS_W-1:0]  rd_data
);

  logic [LS_W-1:0] mem [MAX_WIDTH];
  logic [LS_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; returns the contents before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/c3f_cell.sv -----
// Window cell: holds one pixel column, passes it on, and weights it with three coefficients.
`timescale 1ns / 1ps
`default_nettype none

module c3f_cell import c3f_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cell_ctl_t                ctl,
  input  wire col_t                     col_in,
  input  wire wcol_t                    wts,
  output col_t                          col_out,
  output logic signed [PSUM_W-1:0]      psum
);

  col_t                     col_r;
  logic signed [PROD_W-1:0] prod_top_r, prod_mid_r, prod_bot_r;
  logic signed [PROD_W-1:0] prod_top_nxt, prod_mid_nxt, prod_bot_nxt;

  // Column register; shifts along the chain once per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (ctl.shift) begin
      col_r <= col_in;
    end
  end

  // Unsigned pixel times signed weight, one product per row.
  assign prod_top_nxt = PROD_W'($signed({1'b0, col_r.top})) * PROD_W'($signed(wts.top));
  assign prod_mid_nxt = PROD_W'($signed({1'b0, col_r.mid})) * PROD_W'($signed(wts.mid));
  assign prod_bot_nxt = PROD_W'($signed({1'b0, col_r.bot})) * PROD_W'($signed(wts.bot));

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      prod_top_r <= prod_top_nxt;
      prod_mid_r <= prod_mid_nxt;
      prod_bot_r <= prod_bot_nxt;
    end
  end

  // Column contribution to the window sum.
  assign psum = PSUM_W'(prod_top_r) + PSUM_W'(prod_mid_r) + PSUM_W'(prod_bot_r);

  assign col_out = col_r;

endmodule

`default_nettype wire

// ----- test/tb_conv3x3_clamped_pixel_filter.sv -----
// Self-checking testbench of the 3x3 clamped pixel filter: predicts each filtered pixel.
`timescale 1ns / 1ps

module tb_conv3x3_clamped_pixel_filter;
  import c3f_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PIXELS = 860;

  // One pixel request: value and start-of-frame mark.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             sof;
  } pixel_req_t;

  // One filtered pixel as it should leave the block.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             last;
  } filt_res_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata   = '0;  // [7:0] pixel_in
  logic                  in_tuser   = 1'b0;  // [0] frame_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] pixel_out, [17:8] out_row, [27:18] out_col
  logic                  out_tlast;  // frame_last
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  // Stimulus and checking bookkeeping.
  pixel_req_t pixel_q [$];
  filt_res_t  filtered_q [$];
  filt_res_t  want_res;
  logic       pix_taken     = 1'b0;
  int         send_idle_pct = 31;
  int         recv_idle_pct = 59;
  int         err_count     = 0;
  int         cycle_count   = 0;

  // Predictor copy of the registers and of the filter state.
  logic [DIM_W-1:0]   width_reg  = WIDTH_RESET;
  logic [DIM_W-1:0]   height_reg = HEIGHT_RESET;
  logic [CFG_W-1:0]   coeff_top  = '0;
  logic [CFG_W-1:0]   coeff_mid  = COEFF_MID_RESET;
  logic [CFG_W-1:0]   coeff_bot  = '0;
  bit   [LS_W-1:0]    line_mem [MAX_WIDTH];
  logic [6*PIX_W-1:0] win_cols   = '0;
  int                 col_pos    = 0;
  int                 row_pos    = 0;

  conv3x3_clamped_pixel_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Out-of-range dimensions are pulled into the usable range.
  function automatic int eff_dim(logic [DIM_W-1:0] v, int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Advances the filter state by one pixel and queues the result it completes, if any.
  function automatic void filter_pixel(pixel_req_t req);
    int                 w;
    int                 h;
    int                 c;
    int                 r;
    logic [LS_W-1:0]    ls;
    logic [3*PIX_W-1:0] newcol;
    logic [3*PIX_W-1:0] cols [3];
    logic [CFG_W-1:0]   wrow;
    shortint            wgt;
    longint             acc;
    filt_res_t          res;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    if (req.sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    ls = (c < MAX_WIDTH) ? line_mem[c] : '0;
    newcol = {ls, req.value};

    // An interior centre is complete: weighted sum, then clamp and truncate.
    if (r >= 2 && c >= 2 && c < w && r < h) begin
      cols[0] = win_cols[6*PIX_W-1:3*PIX_W];
      cols[1] = win_cols[3*PIX_W-1:0];
      cols[2] = newcol;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        wrow = (i == 0) ? coeff_top : (i == 1) ? coeff_mid : coeff_bot;
        for (int j = 0; j < 3; j++) begin
          wgt = wrow[j*COEF_W +: COEF_W];
          acc += longint'(cols[j][(2-i)*PIX_W +: PIX_W]) * longint'(wgt);
        end
      end
      if (acc < 0) res.value = '0;
      else if ((acc >>> COEF_FRAC_BITS) > 255) res.value = PIX_MAX;
      else res.value = PIX_W'(acc >>> COEF_FRAC_BITS);
      res.row  = ROW_W'(r - 1);
      res.col  = ROW_W'(c - 1);
      res.last = (r == h - 1) && (c == w - 1);
      filtered_q.push_back(res);
    end

    // Line store, window and position update.
    if (c < MAX_WIDTH) line_mem[c] = {ls[PIX_W-1:0], req.value};
    win_cols = {win_cols[3*PIX_W-1:0], newcol};
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Sampling at the rising edge: accepted pixels, register writes and results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      pix_taken = in_tvalid && in_tready;
      if (pix_taken) filter_pixel('{value: in_tdata, sof: in_tuser});
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_IMAGE_WIDTH:  width_reg  = cfg_wdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_wdata[DIM_W-1:0];
          REG_COEFF_TOP:    coeff_top  = cfg_wdata;
          REG_COEFF_MID:    coeff_mid  = cfg_wdata;
          REG_COEFF_BOTTOM: coeff_bot  = cfg_wdata;
          default: ;
        endcase
      end
      if (rst_n && out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, actual data %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want_res = filtered_q.pop_front();
          check_field("pixel_out", want_res.value, out_tdata[7:0]);
          check_field("out_row", want_res.row, out_tdata[17:8]);
          check_field("out_col", want_res.col, out_tdata[27:18]);
          check_field("frame_last", want_res.last, out_tlast);
          check_field("padding", 0, out_tdata[31:28]);
        end
      end
    end
  end

  // Pixel driver and result back-pressure, both changed at the falling edge.
  always @(negedge clk) begin
    pixel_req_t req;
    if (!in_tvalid || pix_taken) begin
      if (rst_n && pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pixel_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= req.value;
        in_tuser  <= req.sof;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void queue_pixel(int value, bit sof);
    pixel_q.push_back('{value: PIX_W'(value), sof: sof});
  endfunction

  function automatic int rand_pixel();
    case ($urandom_range(9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Weights: moderate ones most often, with extremes, zeros and raw patterns mixed in.
  function automatic logic [COEF_W-1:0] rand_weight();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return '0;
      4, 5: return COEF_W'($urandom_range(65535));
      default: return COEF_W'($urandom_range(512) - 128);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_coeff_row();
    return {rand_weight(), rand_weight(), rand_weight()};
  endfunction

  function automatic int rand_width();
    case ($urandom_range(7))
      0: return $urandom_range(2);
      1: return $urandom_range(13, 40);
      default: return $urandom_range(3, 12);
    endcase
  endfunction

  function automatic int rand_height();
    case ($urandom_range(7))
      0: return $urandom_range(2);
      1: return $urandom_range(1000, 2047);
      default: return $urandom_range(3, 7);
    endcase
  endfunction

  // A dimension word with junk above the register width.
  function automatic logic [CFG_W-1:0] dim_word(int v);
    logic [63:0] word;
    word = {$urandom, $urandom};
    word[DIM_W-1:0] = DIM_W'(v);
    return word[CFG_W-1:0];
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every request has gone in and every result has come out.
  task automatic settle();
    while (pixel_q.size() != 0 || in_tvalid || filtered_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int random_sent;
    int rows;
    int n;
    int stray;
    int old_w;
    int w;
    int h;
    bit restart;
    bit sof;
    int pat_a [9];
    int pat_b [12];
    random_sent = 0;
    pat_a = '{0, 255, 17, 128, 255, 1, 254, 0, 99};
    pat_b = '{0, 0, 0, 255, 255, 0, 0, 0, 7, 200, 9, 3};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Smallest frame under the reset weights: the centre passes through.
    write_reg(REG_IMAGE_WIDTH, CFG_W'(0));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
    foreach (pat_a[k]) queue_pixel(pat_a[k], k == 0);

    // Extreme weights: one centre clamps to zero, the other saturates.
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(4));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
    write_reg(REG_COEFF_TOP, 48'h7FFF_7FFF_7FFF);
    write_reg(REG_COEFF_MID, 48'h8000_8000_8000);
    write_reg(REG_COEFF_BOTTOM, 48'h0000_0100_0000);
    foreach (pat_b[k]) queue_pixel(pat_b[k], k == 0);

    // Half weight truncates; the width then shrinks in the middle of a row.
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(5));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(4));
    write_reg(REG_COEFF_TOP, '0);
    write_reg(REG_COEFF_MID, 48'h0000_0080_0000);
    write_reg(REG_COEFF_BOTTOM, '0);
    for (int k = 0; k < 14; k++) queue_pixel(rand_pixel() | 1, k == 0);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
    for (int k = 0; k < 4; k++) queue_pixel(rand_pixel(), 1'b0);

    // Widest rows: one full row and a few pixels, then a narrow width ends the second row,
    // and the short third row only gives results if the first row wrapped at the limit.
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(2047));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(1));
    write_reg(REG_COEFF_TOP, rand_coeff_row());
    write_reg(REG_COEFF_MID, rand_coeff_row());
    write_reg(REG_COEFF_BOTTOM, rand_coeff_row());
    for (int k = 0; k < MAX_WIDTH + 4; k++) queue_pixel(rand_pixel(), k == 0);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
    for (int k = 0; k < 4; k++) queue_pixel(rand_pixel(), 1'b0);

    // Random runs of whole frames with random settings, some broken or cut short.
    while (random_sent < RANDOM_PIXELS) begin
      settle();
      if (random_sent >= 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end else if (random_sent >= RANDOM_PIXELS / 3) begin
        send_idle_pct <= 59;
        recv_idle_pct <= 31;
      end
      restart = 1'b0;
      old_w = eff_dim(width_reg, MAX_WIDTH);
      if (old_w > 40 || $urandom_range(2) != 0) begin
        write_reg(REG_IMAGE_WIDTH, dim_word(rand_width()));
        // A wider row would read line store entries that this frame never wrote.
        if (eff_dim(width_reg, MAX_WIDTH) > old_w) restart = 1'b1;
      end
      if ($urandom_range(2) == 0) write_reg(REG_IMAGE_HEIGHT, dim_word(rand_height()));
      if ($urandom_range(3) == 0) write_reg(REG_COEFF_TOP, rand_coeff_row());
      if ($urandom_range(3) == 0) write_reg(REG_COEFF_MID, rand_coeff_row());
      if ($urandom_range(3) == 0) write_reg(REG_COEFF_BOTTOM, rand_coeff_row());
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      sof = restart || ($urandom_range(3) != 0);
      rows = (h <= 8) ? h * $urandom_range(1, 3) : $urandom_range(3, 6);
      n = rows * w;
      if ($urandom_range(9) == 0) n = $urandom_range(1, n);
      stray = ($urandom_range(9) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int k = 0; k < n; k++) queue_pixel(rand_pixel(), (k == 0 && sof) || k == stray);
      random_sent += n;
    end

    settle();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
